@@ rtl/modular_arithmetic_unit_assert.svh @@
// Assertion macros for the modular arithmetic unit.
// Used by the top level only; the macros expand to nothing under SYNTHESIS.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MAU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MAU_ASSERT_SAME(label, ante, cons, msg)
`define MAU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/mau_pkg.sv @@
// Shared types and codes of the modular arithmetic unit.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package mau_pkg;
	localparam int ModeWidth = 3;
	localparam int CmdWidth  = 5;

	localparam logic [ModeWidth-1:0] MODE_ADD = 3'd0;
	localparam logic [ModeWidth-1:0] MODE_SUB = 3'd1;
	localparam logic [ModeWidth-1:0] MODE_MUL = 3'd2;
	localparam logic [ModeWidth-1:0] MODE_DIV = 3'd3;
	localparam logic [ModeWidth-1:0] MODE_POW = 3'd4;
	localparam logic [ModeWidth-1:0] MODE_NEG = 3'd5;
	localparam logic [ModeWidth-1:0] MODE_INV = 3'd6;

	localparam logic [CmdWidth-1:0] CMD_NONE     = 5'd0;
	localparam logic [CmdWidth-1:0] CMD_LOAD     = 5'd1;
	localparam logic [CmdWidth-1:0] CMD_DIV_A    = 5'd2;
	localparam logic [CmdWidth-1:0] CMD_DIV_B    = 5'd3;
	localparam logic [CmdWidth-1:0] CMD_DIV_PROD = 5'd4;
	localparam logic [CmdWidth-1:0] CMD_DIV_EUC  = 5'd5;
	localparam logic [CmdWidth-1:0] CMD_WB_A     = 5'd6;
	localparam logic [CmdWidth-1:0] CMD_WB_B     = 5'd7;
	localparam logic [CmdWidth-1:0] CMD_WB_RET   = 5'd8;
	localparam logic [CmdWidth-1:0] CMD_WB_BASE  = 5'd9;
	localparam logic [CmdWidth-1:0] CMD_WB_RES   = 5'd10;
	localparam logic [CmdWidth-1:0] CMD_WB_EUC   = 5'd11;
	localparam logic [CmdWidth-1:0] CMD_MUL_AB   = 5'd12;
	localparam logic [CmdWidth-1:0] CMD_MUL_AI   = 5'd13;
	localparam logic [CmdWidth-1:0] CMD_MUL_RB   = 5'd14;
	localparam logic [CmdWidth-1:0] CMD_MUL_BB   = 5'd15;
	localparam logic [CmdWidth-1:0] CMD_MUL_EUC  = 5'd16;
	localparam logic [CmdWidth-1:0] CMD_EUC_INIT = 5'd17;
	localparam logic [CmdWidth-1:0] CMD_EUC_UPD  = 5'd18;
	localparam logic [CmdWidth-1:0] CMD_EUC_FIN  = 5'd19;
	localparam logic [CmdWidth-1:0] CMD_POW_INIT = 5'd20;
	localparam logic [CmdWidth-1:0] CMD_FIN_ADD  = 5'd21;
	localparam logic [CmdWidth-1:0] CMD_FIN_SUB  = 5'd22;
	localparam logic [CmdWidth-1:0] CMD_FIN_NEG  = 5'd23;
	localparam logic [CmdWidth-1:0] CMD_FIN_INV  = 5'd24;
	localparam logic [CmdWidth-1:0] CMD_FIN_RET  = 5'd25;
	localparam logic [CmdWidth-1:0] CMD_FIN_ZERO = 5'd26;
	localparam logic [CmdWidth-1:0] CMD_COMMIT   = 5'd27;

	typedef struct packed {
		logic [CmdWidth-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic                 div_done;
		logic                 e_zero;
		logic                 e_neg;
		logic                 e_lsb;
		logic                 eb_zero;
		logic [ModeWidth-1:0] mode;
	} status_t;
endpackage

@@ rtl/mau_div.sv @@
// Restoring divider, one quotient bit per cycle, short (W-bit) or long (2W-bit) dividend.
// Standalone; used by the datapath for every reduction and every Euclid step.
`timescale 1ns / 1ps
module mau_div #(
	parameter int W = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           long_op,
	input  logic [2*W-1:0] dividend,
	input  logic [W-1:0]   divisor,
	output logic           done,
	output logic [W-1:0]   rem,
	output logic [W-1:0]   quot
);
	localparam int CW = $clog2(2 * W + 1);
	localparam logic [CW-1:0] CNT_LONG  = CW'(2 * W);
	localparam logic [CW-1:0] CNT_SHORT = CW'(W);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [2*W-1:0] dvd_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   dsr_q;
	logic [W:0]     trial;
	logic           qbit;

	assign trial = {rem_q, dvd_q[2*W-1]};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= long_op ? CNT_LONG : CNT_SHORT;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= long_op ? dividend : {dividend[W-1:0], {W{1'b0}}};
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? W'(trial - {1'b0, dsr_q}) : trial[W-1:0];
			dvd_q <= {dvd_q[2*W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
	assign quot = dvd_q[W-1:0];
endmodule

@@ rtl/mau_datapath.sv @@
// Datapath of the modular arithmetic unit: operand, power and Euclid registers,
// one multiplier and the shared divider. Depends on mau_pkg and mau_div.
`timescale 1ns / 1ps
module mau_datapath import mau_pkg::*; #(
	parameter int VW = 31,
	parameter int EW = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [VW-1:0]        cfg_data,
	input  logic [ModeWidth-1:0] mode,
	input  logic [VW-1:0]        operand_a,
	input  logic [VW-1:0]        operand_b,
	input  logic signed [EW-1:0] exponent,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic [VW-1:0]        result,
	output logic                 not_invertible
);
	localparam int SW = VW + 2;

	logic [VW-1:0]        modulus_q;
	logic [VW-1:0]        m_q;
	logic [ModeWidth-1:0] mode_q;
	logic [VW-1:0]        a_q, b_q, ret_q, base_q, ea_q, eb_q, q_q, inv_q;
	logic [EW-1:0]        exp_q, e_q;
	logic signed [SW-1:0] u_q, v_q;
	logic signed [2*SW-1:0] prod_q;
	logic [VW-1:0]        res_w_q, result_q;
	logic                 bad_w_q, nonv_q;

	logic                 div_start, div_long, div_done;
	logic [2*VW-1:0]      div_dvd;
	logic [VW-1:0]        div_dsr, div_rem, div_quot;
	logic                 mul_en;
	logic signed [SW-1:0] mul_x, mul_y;
	logic [VW:0]          msx, sum, diff;
	logic signed [SW-1:0] m_s, u_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= VW'(32'd1000000007);
		end else if (cfg_valid) begin
			modulus_q <= cfg_data;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_long  = 1'b0;
		div_dvd   = '0;
		div_dsr   = m_q;
		case (cmd.op)
			CMD_DIV_A: begin
				div_start = 1'b1;
				div_dvd   = {{VW{1'b0}}, a_q};
			end
			CMD_DIV_B: begin
				div_start = 1'b1;
				div_dvd   = {{VW{1'b0}}, b_q};
			end
			CMD_DIV_PROD: begin
				div_start = 1'b1;
				div_long  = 1'b1;
				div_dvd   = prod_q[2*VW-1:0];
			end
			CMD_DIV_EUC: begin
				div_start = 1'b1;
				div_dvd   = {{VW{1'b0}}, ea_q};
				div_dsr   = eb_q;
			end
			default: ;
		endcase
	end

	mau_div #(.W(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.long_op  (div_long),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.rem      (div_rem),
		.quot     (div_quot)
	);

	always_comb begin
		mul_en = 1'b1;
		mul_x  = '0;
		mul_y  = '0;
		case (cmd.op)
			CMD_MUL_AB: begin
				mul_x = {2'b00, a_q};
				mul_y = {2'b00, b_q};
			end
			CMD_MUL_AI: begin
				mul_x = {2'b00, a_q};
				mul_y = {2'b00, inv_q};
			end
			CMD_MUL_RB: begin
				mul_x = {2'b00, ret_q};
				mul_y = {2'b00, base_q};
			end
			CMD_MUL_BB: begin
				mul_x = {2'b00, base_q};
				mul_y = {2'b00, base_q};
			end
			CMD_MUL_EUC: begin
				mul_x = {2'b00, q_q};
				mul_y = v_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign msx  = {1'b0, m_q};
	assign sum  = {1'b0, a_q} + {1'b0, b_q};
	assign diff = {1'b0, a_q} + msx - {1'b0, b_q};
	assign m_s  = {2'b00, m_q};

	// Euclid coefficient lies within one modulus of the range; fold it back once
	always_comb begin
		if (u_q < 0)
			u_fix = u_q + m_s;
		else if (u_q >= m_s)
			u_fix = u_q - m_s;
		else
			u_fix = u_q;
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_x * mul_y;
		case (cmd.op)
			CMD_LOAD: begin
				m_q     <= (modulus_q == '0) ? VW'(1) : modulus_q;
				mode_q  <= mode;
				a_q     <= operand_a;
				b_q     <= operand_b;
				exp_q   <= exponent;
				bad_w_q <= 1'b0;
			end
			CMD_WB_A:    a_q <= div_rem;
			CMD_WB_B:    b_q <= div_rem;
			CMD_WB_RET:  ret_q <= div_rem;
			CMD_WB_BASE: begin
				base_q <= div_rem;
				e_q    <= e_q >> 1;
			end
			CMD_WB_RES:  res_w_q <= div_rem;
			CMD_WB_EUC: begin
				ea_q <= eb_q;
				eb_q <= div_rem;
				q_q  <= div_quot;
			end
			CMD_EUC_INIT: begin
				ea_q <= (mode_q == MODE_DIV) ? b_q : a_q;
				eb_q <= m_q;
				u_q  <= SW'(1);
				v_q  <= '0;
			end
			CMD_EUC_UPD: begin
				u_q <= v_q;
				v_q <= u_q - prod_q[SW-1:0];
			end
			CMD_EUC_FIN: begin
				bad_w_q <= (ea_q != VW'(1));
				inv_q   <= u_fix[VW-1:0];
			end
			CMD_POW_INIT: begin
				ret_q  <= (m_q == VW'(1)) ? '0 : VW'(1);
				base_q <= a_q;
				e_q    <= exp_q;
			end
			CMD_FIN_ADD:  res_w_q <= (sum >= msx) ? VW'(sum - msx) : sum[VW-1:0];
			CMD_FIN_SUB:  res_w_q <= (diff >= msx) ? VW'(diff - msx) : diff[VW-1:0];
			CMD_FIN_NEG:  res_w_q <= (a_q == '0) ? '0 : VW'(m_q - a_q);
			CMD_FIN_INV:  res_w_q <= inv_q;
			CMD_FIN_RET:  res_w_q <= ret_q;
			CMD_FIN_ZERO: res_w_q <= '0;
			CMD_COMMIT: begin
				result_q <= res_w_q;
				nonv_q   <= bad_w_q;
			end
			default: ;
		endcase
	end

	assign status.div_done = div_done;
	assign status.e_zero   = (e_q == '0);
	assign status.e_neg    = e_q[EW-1];
	assign status.e_lsb    = e_q[0];
	assign status.eb_zero  = (eb_q == '0);
	assign status.mode     = mode_q;

	assign result         = result_q;
	assign not_invertible = nonv_q;
endmodule

@@ rtl/mau_ctrl.sv @@
// Controller of the modular arithmetic unit: sequences reductions, power and Euclid.
// Depends on mau_pkg; drives the datapath by command codes.
`timescale 1ns / 1ps
module mau_ctrl import mau_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RA     = 5'd1;
	localparam logic [4:0] S_RA_W   = 5'd2;
	localparam logic [4:0] S_RB     = 5'd3;
	localparam logic [4:0] S_RB_W   = 5'd4;
	localparam logic [4:0] S_DISP   = 5'd5;
	localparam logic [4:0] S_M1     = 5'd6;
	localparam logic [4:0] S_M2     = 5'd7;
	localparam logic [4:0] S_P_TEST = 5'd8;
	localparam logic [4:0] S_P_R1   = 5'd9;
	localparam logic [4:0] S_P_R2   = 5'd10;
	localparam logic [4:0] S_P_SQ   = 5'd11;
	localparam logic [4:0] S_P_B1   = 5'd12;
	localparam logic [4:0] S_P_B2   = 5'd13;
	localparam logic [4:0] S_E_TEST = 5'd14;
	localparam logic [4:0] S_E_D    = 5'd15;
	localparam logic [4:0] S_E_M    = 5'd16;
	localparam logic [4:0] S_E_U    = 5'd17;
	localparam logic [4:0] S_E_FIN  = 5'd18;
	localparam logic [4:0] S_COMMIT = 5'd19;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;
	logic       commit_ok;

	assign commit_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd.op  = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = CMD_LOAD;
					state_d = S_RA;
				end
			end
			S_RA: begin
				cmd.op  = CMD_DIV_A;
				state_d = S_RA_W;
			end
			S_RA_W: begin
				if (status.div_done) begin
					cmd.op  = CMD_WB_A;
					state_d = S_RB;
				end
			end
			S_RB: begin
				cmd.op  = CMD_DIV_B;
				state_d = S_RB_W;
			end
			S_RB_W: begin
				if (status.div_done) begin
					cmd.op  = CMD_WB_B;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (status.mode) inside
					MODE_ADD: begin
						cmd.op  = CMD_FIN_ADD;
						state_d = S_COMMIT;
					end
					MODE_SUB: begin
						cmd.op  = CMD_FIN_SUB;
						state_d = S_COMMIT;
					end
					MODE_MUL: begin
						cmd.op  = CMD_MUL_AB;
						state_d = S_M1;
					end
					MODE_POW: begin
						cmd.op  = CMD_POW_INIT;
						state_d = S_P_TEST;
					end
					MODE_NEG: begin
						cmd.op  = CMD_FIN_NEG;
						state_d = S_COMMIT;
					end
					MODE_DIV, MODE_INV: begin
						cmd.op  = CMD_EUC_INIT;
						state_d = S_E_TEST;
					end
					default: begin
						cmd.op  = CMD_FIN_ZERO;
						state_d = S_COMMIT;
					end
				endcase
			end
			S_M1: begin
				cmd.op  = CMD_DIV_PROD;
				state_d = S_M2;
			end
			S_M2: begin
				if (status.div_done) begin
					cmd.op  = CMD_WB_RES;
					state_d = S_COMMIT;
				end
			end
			S_P_TEST: begin
				if (status.e_neg || status.e_zero) begin
					cmd.op  = CMD_FIN_RET;
					state_d = S_COMMIT;
				end else if (status.e_lsb) begin
					cmd.op  = CMD_MUL_RB;
					state_d = S_P_R1;
				end else begin
					state_d = S_P_SQ;
				end
			end
			S_P_R1: begin
				cmd.op  = CMD_DIV_PROD;
				state_d = S_P_R2;
			end
			S_P_R2: begin
				if (status.div_done) begin
					cmd.op  = CMD_WB_RET;
					state_d = S_P_SQ;
				end
			end
			S_P_SQ: begin
				cmd.op  = CMD_MUL_BB;
				state_d = S_P_B1;
			end
			S_P_B1: begin
				cmd.op  = CMD_DIV_PROD;
				state_d = S_P_B2;
			end
			S_P_B2: begin
				// squared base lands and the exponent advances by one bit
				if (status.div_done) begin
					cmd.op  = CMD_WB_BASE;
					state_d = S_P_TEST;
				end
			end
			S_E_TEST: begin
				if (status.eb_zero) begin
					cmd.op  = CMD_EUC_FIN;
					state_d = S_E_FIN;
				end else begin
					cmd.op  = CMD_DIV_EUC;
					state_d = S_E_D;
				end
			end
			S_E_D: begin
				if (status.div_done) begin
					cmd.op  = CMD_WB_EUC;
					state_d = S_E_M;
				end
			end
			S_E_M: begin
				cmd.op  = CMD_MUL_EUC;
				state_d = S_E_U;
			end
			S_E_U: begin
				cmd.op  = CMD_EUC_UPD;
				state_d = S_E_TEST;
			end
			S_E_FIN: begin
				if (status.mode == MODE_DIV) begin
					cmd.op  = CMD_MUL_AI;
					state_d = S_M1;
				end else begin
					cmd.op  = CMD_FIN_INV;
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				// hold the result until the output register frees up
				if (commit_ok) begin
					cmd.op  = CMD_COMMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == CMD_COMMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
endmodule

@@ rtl/modular_arithmetic_unit.sv @@
// Add, subtract, negate: two short reductions; multiply: one long one more; power adds up
// to two per exponent bit; inverse a divide and multiply per Euclid step, divide one multiply.
// Most time goes to the single-bit-per-cycle shared divider; one item is in work at a time.
// The finished result sits in the output register while the next transaction is taken.
// Reset (async, active low) clears control state and loads the modulus with 1000000007.
`timescale 1ns / 1ps
`include "modular_arithmetic_unit_assert.svh"
module modular_arithmetic_unit import mau_pkg::*; #(
	parameter int VALUE_WIDTH    = 31,
	parameter int EXPONENT_WIDTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [VALUE_WIDTH-1:0]           cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ModeWidth-1:0]             mode,
	input  logic [VALUE_WIDTH-1:0]           operand_a,
	input  logic [VALUE_WIDTH-1:0]           operand_b,
	input  logic signed [EXPONENT_WIDTH-1:0] exponent,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [VALUE_WIDTH-1:0]           result,
	output logic                             not_invertible
);
	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	mau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mau_datapath #(.VW(VALUE_WIDTH), .EW(EXPONENT_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.exponent       (exponent),
		.cmd            (cmd),
		.status         (status),
		.result         (result),
		.not_invertible (not_invertible)
	);

	`MAU_ASSERT_SAME(a_load_on_accept, in_valid && in_ready, cmd.op == CMD_LOAD, "accept without load")
	`MAU_ASSERT_SAME(a_commit_free, cmd.op == CMD_COMMIT, !out_valid || out_ready, "commit over pending result")
	`MAU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")
endmodule

@@ tb/tb_modular_arithmetic_unit.sv @@
// Self-checking bench for modular_arithmetic_unit: random and directed operations
// across several modulus settings, checked against an in-bench model of the math.
// Depends on mau_pkg and the RTL of modular_arithmetic_unit.
`timescale 1ns / 1ps
module tb_modular_arithmetic_unit;
	import mau_pkg::*;

	localparam int VW = 31;
	localparam int EW = 64;
	localparam logic [ModeWidth-1:0] MODE_NONE = 3'd7;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [ModeWidth-1:0] md;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		logic signed [EW-1:0] ex;
	} op_t;

	typedef struct {
		logic [VW-1:0] value;
		logic bad;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [VW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ModeWidth-1:0] mode = '0;
	logic [VW-1:0] operand_a = '0;
	logic [VW-1:0] operand_b = '0;
	logic signed [EW-1:0] exponent = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VW-1:0] result;
	logic not_invertible;

	op_t pending_ops[$];
	res_t expected_results[$];
	logic [VW-1:0] cur_modulus = 31'd1000000007;
	int errors = 0;
	int checked = 0;
	int in_gap = 0;
	int out_stall = 0;
	longint cycles = 0;

	modular_arithmetic_unit #(.VALUE_WIDTH(VW), .EXPONENT_WIDTH(EW)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.operand_a(operand_a), .operand_b(operand_b), .exponent(exponent),
		.out_valid(out_valid), .out_ready(out_ready),
		.result(result), .not_invertible(not_invertible)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Extended Euclid: coefficient u mod m with u*x == gcd(x, m).
	function automatic longint euclid_coef(input longint x, input longint m, output logic bad);
		longint a, b, u, v, q, r, w, red;
		a = x; b = m; u = 1; v = 0;
		while (b != 0) begin
			q = a / b;
			r = a - q * b;
			w = u - q * v;
			a = b; b = r;
			u = v; v = w;
		end
		bad = (a != 1);
		red = u % m;
		if (red < 0)
			red += m;
		return red;
	endfunction

	function automatic res_t mod_predict(input op_t op, input logic [VW-1:0] modulus);
		res_t r;
		longint unsigned m, a, b, base, e, acc;
		longint coef;
		logic bad;
		m = (modulus == 0) ? 1 : modulus;
		a = op.a % m;
		b = op.b % m;
		bad = 1'b0;
		acc = 0;
		case (op.md)
			MODE_ADD: acc = (a + b) % m;
			MODE_SUB: acc = (a + m - b) % m;
			MODE_MUL: acc = (a * b) % m;
			MODE_DIV: begin
				coef = euclid_coef(longint'(b), longint'(m), bad);
				acc = (a * longint'(coef)) % m;
			end
			MODE_POW: begin
				acc = 1 % m;
				if (!op.ex[EW-1]) begin
					e = op.ex;
					base = a;
					while (e != 0) begin
						if (e[0])
							acc = (acc * base) % m;
						base = (base * base) % m;
						e >>= 1;
					end
				end
			end
			MODE_NEG: acc = (m - a) % m;
			MODE_INV: begin
				coef = euclid_coef(longint'(a), longint'(m), bad);
				acc = coef;
			end
			default: acc = 0;
		endcase
		r.value = acc[VW-1:0];
		r.bad = bad;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [VW-1:0] pick_operand(input logic [VW-1:0] modulus);
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return VW'($urandom_range(0, 3));
			1: return {VW{1'b1}};
			2: return modulus;
			3: return (modulus != 0) ? VW'(modulus * $urandom_range(1, 3)) : 31'd0;
			4: return (modulus != 0) ? VW'(modulus - 1) : 31'd0;
			default: return VW'($urandom);
		endcase
	endfunction

	function automatic op_t random_op(input logic [VW-1:0] modulus);
		op_t op;
		int r;
		op.md = ModeWidth'($urandom_range(0, 7));
		if (op.md == MODE_NONE && $urandom_range(0, 1))
			op.md = MODE_POW;
		op.a = pick_operand(modulus);
		op.b = pick_operand(modulus);
		op.ex = {$urandom, $urandom};
		if (op.md == MODE_POW) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				op.ex[EW-1] = 1'b1;
			else if (r < 75)
				op.ex = EW'($urandom_range(0, 300));
			else if (r < 97)
				op.ex = {32'd0, 32'($urandom)};
			else
				op.ex[EW-1] = 1'b0;
		end
		return op;
	endfunction

	function automatic op_t mk(input logic [ModeWidth-1:0] md, input logic [VW-1:0] a,
			input logic [VW-1:0] b, input logic signed [EW-1:0] ex);
		op_t op;
		op.md = md; op.a = a; op.b = b; op.ex = ex;
		return op;
	endfunction

	// Input driver: hold payload until accepted, then advance to next op or idle.
	always @(posedge clk or negedge arst_n) begin
		op_t op;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				op = pending_ops.pop_front();
				mode <= op.md;
				operand_a <= op.a;
				operand_b <= op.b;
				exponent <= op.ex;
				in_valid <= 1'b1;
				in_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random backpressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 0;
		end else if (out_stall > 0) begin
			out_stall--;
			out_ready <= 1'b0;
		end else begin
			out_stall = pick_gap();
			out_ready <= (out_stall == 0);
		end
	end

	// Monitor: track the register, predict on each input transaction, check outputs.
	always @(posedge clk) begin
		res_t want;
		op_t op;
		if (arst_n) begin
			cycles++;
			if (cfg_valid && cfg_ready)
				cur_modulus = cfg_data;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %0d ni=%0d", $realtime, result,
						not_invertible);
					errors++;
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (result !== want.value) begin
						$display("%0t: result mismatch exp %0d got %0d", $realtime,
							want.value, result);
						errors++;
					end
					if (not_invertible !== want.bad) begin
						$display("%0t: not_invertible mismatch exp %0d got %0d", $realtime,
							want.bad, not_invertible);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				op.md = mode; op.a = operand_a; op.b = operand_b; op.ex = exponent;
				expected_results.push_back(mod_predict(op, cur_modulus));
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding", $realtime,
					expected_results.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_ops.size() != 0 || expected_results.size() != 0 || in_valid)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_modulus(input logic [VW-1:0] value);
		@(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [VW-1:0] moduli[9];
		int counts[9];
		moduli = '{31'd2147483647, 31'd2, 31'd1000000000, 31'd0, 31'd1, 31'd97,
			31'd65536, 31'd1000000007, 31'd3};
		counts = '{200, 60, 200, 30, 30, 150, 150, 180, 50};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Directed ops at the reset modulus.
		pending_ops.push_back(mk(MODE_ADD, {VW{1'b1}}, {VW{1'b1}}, 0));
		pending_ops.push_back(mk(MODE_ADD, 31'd1000000006, 31'd1, 0));
		pending_ops.push_back(mk(MODE_SUB, 31'd0, 31'd5, 0));
		pending_ops.push_back(mk(MODE_SUB, 31'd1000000007, 31'd1000000007, 0));
		pending_ops.push_back(mk(MODE_MUL, {VW{1'b1}}, 31'd1000000006, 0));
		pending_ops.push_back(mk(MODE_DIV, 31'd10, 31'd0, 0));
		pending_ops.push_back(mk(MODE_DIV, 31'd10, 31'd1000000007, 0));
		pending_ops.push_back(mk(MODE_DIV, 31'd12345, 31'd678, 0));
		pending_ops.push_back(mk(MODE_POW, 31'd3, 31'd0, 0));
		pending_ops.push_back(mk(MODE_POW, 31'd3, 31'd0, -1));
		pending_ops.push_back(mk(MODE_POW, 31'd3, 31'd0, {1'b1, 63'd0}));
		pending_ops.push_back(mk(MODE_POW, 31'd2, 31'd0, {1'b0, {63{1'b1}}}));
		pending_ops.push_back(mk(MODE_POW, 31'd0, 31'd0, 5));
		pending_ops.push_back(mk(MODE_POW, 31'd1000000007, 31'd0, 0));
		pending_ops.push_back(mk(MODE_NEG, 31'd0, 31'd0, 0));
		pending_ops.push_back(mk(MODE_NEG, 31'd1000000007, 31'd0, 0));
		pending_ops.push_back(mk(MODE_NEG, {VW{1'b1}}, 31'd0, 0));
		pending_ops.push_back(mk(MODE_INV, 31'd0, 31'd0, 0));
		pending_ops.push_back(mk(MODE_INV, 31'd1, 31'd0, 0));
		pending_ops.push_back(mk(MODE_INV, 31'd1000000006, 31'd0, 0));
		pending_ops.push_back(mk(MODE_NONE, {VW{1'b1}}, {VW{1'b1}}, -1));
		for (int i = 0; i < 40; i++)
			pending_ops.push_back(random_op(cur_modulus));
		drain();
		// Sweep moduli: extremes, composites, degenerate zero and one.
		for (int p = 0; p < 9; p++) begin
			write_modulus(moduli[p]);
			@(negedge clk);
			pending_ops.push_back(mk(MODE_INV, 31'd0, 31'd0, 0));
			pending_ops.push_back(mk(MODE_DIV, {VW{1'b1}}, 31'd2, 0));
			pending_ops.push_back(mk(MODE_INV, 31'd10, 31'd0, 0));
			for (int i = 0; i < counts[p]; i++)
				pending_ops.push_back(random_op(moduli[p]));
			drain();
		end
		$display("Checked %0d results over 10 modulus settings incl. 0, 1, 2 and 2^31-1,",
			checked);
		$display("all seven operations plus the unused mode, with random stalls both sides.");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/mau_pkg.sv
rtl/mau_div.sv
rtl/mau_datapath.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit.sv
tb/tb_modular_arithmetic_unit.sv
